// File: hw/rtl/randomized_set_table_unit_macros.svh
// assertion macros for the randomized set table unit
`ifndef RANDOMIZED_SET_TABLE_UNIT_MACROS_SVH
`define RANDOMIZED_SET_TABLE_UNIT_MACROS_SVH

// property holds at every clock edge out of reset
`define RSTU_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("randomized set table: invariant violated");

// same-cycle implication
`define RSTU_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("randomized set table: implication violated");

// next-cycle implication
`define RSTU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("randomized set table: next-cycle check violated");

`endif

// File: hw/rtl/rset_pkg.sv
// types and constants shared by the randomized set table unit
`timescale 1ns / 1ps
package rset_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int TOT_W    = $clog2(CAPACITY + 1);

	localparam int OPC_W    = 2;
	localparam int VALUE_W  = 32;
	localparam int RND_W    = 16;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;
	localparam int DIVC_W   = $clog2(RND_W);

	localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OPC_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OPC_W-1:0] OP_PICK   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOCHG = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEARCH,
		S_APPLY,
		S_RM_RD,
		S_RM_WR,
		S_DIV,
		S_PK_RD,
		S_PK_CAP,
		S_FINISH
	} state_t;

endpackage

// File: hw/rtl/rset_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
interface rset_req_if;
	logic                               valid;
	logic                               ready;
	logic [rset_pkg::OPC_W-1:0]         opcode;
	logic signed [rset_pkg::VALUE_W-1:0] value;
	logic [rset_pkg::RND_W-1:0]         random_word;

	modport source (output valid, opcode, value, random_word, input ready);
	modport sink (input valid, opcode, value, random_word, output ready);
endinterface

interface rset_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [rset_pkg::STATUS_W-1:0]      status;
	logic signed [rset_pkg::VALUE_W-1:0] picked_value;
	logic [rset_pkg::COUNT_W-1:0]       member_count;

	modport source (output valid, status, picked_value, member_count, input ready);
	modport sink (input valid, status, picked_value, member_count, output ready);
endinterface

// File: hw/rtl/rset_ram.sv
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps
module rset_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/randomized_set_table_unit.sv
// randomized set table: insert, remove and random pick over a packed store
//
//  channel | dir | payload                                  | handshake
//  --------+-----+------------------------------------------+------------
//  req     | in  | opcode, value, random_word               | valid/ready
//  rsp     | out | status, picked_value, member_count       | valid/ready
//
// insert and remove scan the store one entry a cycle through the ram read
// port, then apply the change; random pick runs 16 modulo steps, then reads
// the chosen entry. req.ready is high only in idle, so a new request is taken
// only once the last one has been moved into the result register.
// the result register frees the sequencer; a stalled rsp holds only the final step.
// arst_n clears the count, state and result valid; the store is not cleared.
`timescale 1ns / 1ps
`include "randomized_set_table_unit_macros.svh"
module randomized_set_table_unit (
	input  logic       clk,
	input  logic       arst_n,
	rset_req_if.sink   req,
	rset_rsp_if.source rsp
);

	rset_pkg::state_t state_q, state_d;

	logic [rset_pkg::OPC_W-1:0]    op_q;
	logic [rset_pkg::VALUE_W-1:0]  value_q;
	logic [rset_pkg::RND_W-1:0]    rnd_q;
	logic [rset_pkg::TOT_W-1:0]    idx_q;
	logic                          chk_q;
	logic                          found_q;
	logic [rset_pkg::IDX_W-1:0]    pos_q;
	logic [rset_pkg::TOT_W-1:0]    total_q;
	logic [rset_pkg::TOT_W-1:0]    rem_q;
	logic [rset_pkg::DIVC_W-1:0]   div_cnt_q;
	logic [rset_pkg::STATUS_W-1:0] status_q;
	logic [rset_pkg::VALUE_W-1:0]  picked_q;

	logic                          out_valid_q;
	logic [rset_pkg::STATUS_W-1:0] out_status_q;
	logic [rset_pkg::VALUE_W-1:0]  out_picked_q;
	logic [rset_pkg::COUNT_W-1:0]  out_count_q;

	logic                          ram_we;
	logic [rset_pkg::IDX_W-1:0]    ram_waddr;
	logic [rset_pkg::VALUE_W-1:0]  ram_wdata;
	logic [rset_pkg::IDX_W-1:0]    ram_raddr;
	logic [rset_pkg::VALUE_W-1:0]  ram_rdata;

	logic                          accept;
	logic                          match;
	logic                          scan_more;
	logic                          search_end;
	logic                          out_free;
	logic                          is_full;
	logic [rset_pkg::TOT_W:0]      trial;
	logic [rset_pkg::TOT_W-1:0]    rem_next;
	logic [rset_pkg::TOT_W-1:0]    last_idx;
	logic                          upd_state;
	logic                          out_not_done;

	rset_ram #(
		.WIDTH(rset_pkg::VALUE_W),
		.DEPTH(rset_pkg::CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign accept     = req.valid && req.ready;
	assign match      = chk_q && (ram_rdata == value_q);
	assign scan_more  = idx_q < total_q;
	assign search_end = !chk_q && !scan_more;
	assign out_free   = !out_valid_q || rsp.ready;
	assign is_full    = total_q >= rset_pkg::TOT_W'(rset_pkg::CAPACITY);
	assign last_idx   = total_q - rset_pkg::TOT_W'(1);

	// restoring modulo step, remainder always stays below the count
	assign trial = {rem_q, rnd_q[rset_pkg::RND_W-1]};
	always_comb begin
		if (trial >= {1'b0, total_q}) begin
			rem_next = rset_pkg::TOT_W'(trial - {1'b0, total_q});
		end else begin
			rem_next = trial[rset_pkg::TOT_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rset_pkg::S_IDLE: begin
				if (req.valid) begin
					if (req.opcode == rset_pkg::OP_INSERT
							|| req.opcode == rset_pkg::OP_REMOVE) begin
						state_d = rset_pkg::S_SEARCH;
					end else if (req.opcode == rset_pkg::OP_PICK && total_q != '0) begin
						state_d = rset_pkg::S_DIV;
					end else begin
						state_d = rset_pkg::S_FINISH;
					end
				end
			end
			rset_pkg::S_SEARCH: begin
				if (match || search_end) begin
					state_d = rset_pkg::S_APPLY;
				end
			end
			rset_pkg::S_APPLY: begin
				if (op_q == rset_pkg::OP_REMOVE && found_q) begin
					state_d = rset_pkg::S_RM_RD;
				end else begin
					state_d = rset_pkg::S_FINISH;
				end
			end
			rset_pkg::S_RM_RD:  state_d = rset_pkg::S_RM_WR;
			rset_pkg::S_RM_WR:  state_d = rset_pkg::S_FINISH;
			rset_pkg::S_DIV: begin
				if (div_cnt_q == rset_pkg::DIVC_W'(rset_pkg::RND_W - 1)) begin
					state_d = rset_pkg::S_PK_RD;
				end
			end
			rset_pkg::S_PK_RD:  state_d = rset_pkg::S_PK_CAP;
			rset_pkg::S_PK_CAP: state_d = rset_pkg::S_FINISH;
			rset_pkg::S_FINISH: begin
				if (out_free) begin
					state_d = rset_pkg::S_IDLE;
				end
			end
			default: state_d = rset_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = total_q[rset_pkg::IDX_W-1:0];
		ram_wdata = value_q;
		ram_raddr = '0;
		unique case (state_q)
			rset_pkg::S_IDLE: req.ready = 1'b1;
			rset_pkg::S_SEARCH: ram_raddr = idx_q[rset_pkg::IDX_W-1:0];
			rset_pkg::S_APPLY: begin
				ram_we = (op_q == rset_pkg::OP_INSERT) && !found_q && !is_full;
			end
			rset_pkg::S_RM_RD: ram_raddr = last_idx[rset_pkg::IDX_W-1:0];
			rset_pkg::S_RM_WR: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = ram_rdata;
			end
			rset_pkg::S_PK_RD: ram_raddr = rem_q[rset_pkg::IDX_W-1:0];
			rset_pkg::S_DIV, rset_pkg::S_PK_CAP, rset_pkg::S_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rset_pkg::S_IDLE;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rset_pkg::S_APPLY && op_q == rset_pkg::OP_INSERT
					&& !found_q && !is_full) begin
				total_q <= total_q + rset_pkg::TOT_W'(1);
			end else if (state_q == rset_pkg::S_RM_WR) begin
				total_q <= last_idx;
			end
			if (state_q == rset_pkg::S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers and result word
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= req.opcode;
			value_q   <= $unsigned(req.value);
			rnd_q     <= req.random_word;
			idx_q     <= '0;
			chk_q     <= 1'b0;
			found_q   <= 1'b0;
			rem_q     <= '0;
			div_cnt_q <= '0;
			picked_q  <= '0;
			status_q  <= (req.opcode == rset_pkg::OP_PICK && total_q == '0)
				? rset_pkg::ST_EMPTY : rset_pkg::ST_DONE;
		end
		case (state_q)
			rset_pkg::S_SEARCH: begin
				if (match) begin
					found_q <= 1'b1;
					pos_q   <= rset_pkg::IDX_W'(idx_q - rset_pkg::TOT_W'(1));
					chk_q   <= 1'b0;
				end else begin
					chk_q <= scan_more;
					if (scan_more) begin
						idx_q <= idx_q + rset_pkg::TOT_W'(1);
					end
				end
			end
			rset_pkg::S_APPLY: begin
				if (op_q == rset_pkg::OP_INSERT) begin
					if (found_q) begin
						status_q <= rset_pkg::ST_NOCHG;
					end else if (is_full) begin
						status_q <= rset_pkg::ST_FULL;
					end
				end else if (!found_q) begin
					status_q <= rset_pkg::ST_NOCHG;
				end
			end
			rset_pkg::S_DIV: begin
				rem_q     <= rem_next;
				rnd_q     <= {rnd_q[rset_pkg::RND_W-2:0], 1'b0};
				div_cnt_q <= div_cnt_q + rset_pkg::DIVC_W'(1);
			end
			rset_pkg::S_PK_CAP: picked_q <= ram_rdata;
			rset_pkg::S_FINISH: begin
				if (out_free) begin
					out_status_q <= status_q;
					out_picked_q <= picked_q;
					out_count_q  <= rset_pkg::COUNT_W'(total_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.picked_value = $signed(out_picked_q);
	assign rsp.member_count = out_count_q;

	// states in which the count and the store may change
	assign upd_state    = state_q == rset_pkg::S_APPLY || state_q == rset_pkg::S_RM_WR;
	assign out_not_done = out_valid_q && out_status_q != rset_pkg::ST_DONE;

	`RSTU_ASSERT_ALWAYS(a_total_in_range, total_q <= rset_pkg::TOT_W'(rset_pkg::CAPACITY))
	`RSTU_ASSERT_NEXT(a_total_only_on_update, !upd_state, $stable(total_q))
	`RSTU_ASSERT_IMPL(a_write_only_on_update, ram_we, upd_state)
	`RSTU_ASSERT_IMPL(a_picked_zero_unless_done, out_not_done, out_picked_q == '0)

endmodule

// File: verif/randomized_set_table_unit_tb.sv
// testbench for the randomized set table unit: directed, fill/drain, stall and random tests
`timescale 1ns / 1ps
module randomized_set_table_unit_tb;
	import rset_pkg::*;

	localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT   = 1500000;
	localparam int RANDOM_ITEMS  = 1215;
	localparam int POOL_SIZE     = 80;
	localparam int DRAIN_CYCLES  = 80;
	localparam int MAX_REPORTED  = 10;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VALUE_W-1:0]  picked;
		logic [COUNT_W-1:0]  count;
	} set_result_t;

	logic clk;
	logic arst_n;

	rset_req_if req_ch ();
	rset_rsp_if rsp_ch ();

	randomized_set_table_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the set, updated when a request word is accepted
	logic [VALUE_W-1:0] shadow_members [CAPACITY];
	int                 shadow_count;
	set_result_t        expected_results [$];
	logic [VALUE_W-1:0] value_pool [POOL_SIZE];

	int  fail_count;
	int  cycle_count;
	int  words_sent;
	int  results_checked;
	int  ops_sent [4];
	int  status_seen [4];
	bit  sender_idle_en;
	bit  receiver_idle_en;
	int  hold_len;
	int  held_cycles;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_results.size());
			$display("** randomized_set_table_unit: FAILED **");
			$finish;
		end
	end

	function automatic int pick_gap(input int floor_len);
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return floor_len;
		if (r < 92) return $urandom_range(floor_len + 1, 3);
		return $urandom_range(12, 40);
	endfunction

	function automatic set_result_t apply_set_op(input logic [OPC_W-1:0] op,
			input logic [VALUE_W-1:0] val, input logic [RND_W-1:0] rnd);
		set_result_t r;
		int slot;
		r = '0;
		r.status = ST_DONE;
		slot = -1;
		for (int i = 0; i < shadow_count; i++) begin
			if (slot < 0 && shadow_members[i] == val) slot = i;
		end
		case (op)
			OP_INSERT: begin
				if (slot >= 0) r.status = ST_NOCHG;
				else if (shadow_count >= CAPACITY) r.status = ST_FULL;
				else begin
					shadow_members[shadow_count] = val;
					shadow_count++;
				end
			end
			OP_REMOVE: begin
				if (slot < 0) r.status = ST_NOCHG;
				else begin
					// last entry fills the hole
					shadow_members[slot] = shadow_members[shadow_count - 1];
					shadow_count--;
				end
			end
			OP_PICK: begin
				if (shadow_count == 0) r.status = ST_EMPTY;
				else r.picked = shadow_members[int'(rnd) % shadow_count];
			end
			default: begin
			end
		endcase
		r.count = shadow_count[COUNT_W-1:0];
		return r;
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTED) $display("[%0d] %s", cycle_count, msg);
	endtask

	// response checker
	always @(posedge clk) begin : rsp_check
		set_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			results_checked++;
			status_seen[rsp_ch.status]++;
			if (expected_results.size() == 0) begin
				note_failure($sformatf("result word with nothing expected: status %0d value %h count %0d",
					rsp_ch.status, rsp_ch.picked_value, rsp_ch.member_count));
			end else begin
				want = expected_results.pop_front();
				if (rsp_ch.status !== want.status || rsp_ch.picked_value !== want.picked
						|| rsp_ch.member_count !== want.count) begin
					note_failure($sformatf(
						"mismatch: status %0d/%0d picked %h/%h count %0d/%0d (expected/actual)",
						want.status, rsp_ch.status, want.picked, rsp_ch.picked_value,
						want.count, rsp_ch.member_count));
				end
			end
		end
	end

	// response ready: random stalls, or a long hold when one is requested
	initial begin : rsp_driver
		int stall;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				rsp_ch.ready <= 1'b0;
				held_cycles = 0;
				while (held_cycles < hold_len) begin
					@(negedge clk);
					held_cycles++;
				end
				hold_len = 0;
				rsp_ch.ready <= 1'b1;
			end else if (receiver_idle_en && $urandom_range(0, 3) == 0) begin
				stall = pick_gap(1);
				rsp_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// leaves valid high after acceptance; an idle gap before the next send, or the final drain, lowers it
	task automatic send_word(input logic [OPC_W-1:0] op, input logic [VALUE_W-1:0] val,
			input logic [RND_W-1:0] rnd);
		int gap;
		set_result_t exp_item;
		gap = sender_idle_en ? pick_gap(0) : 0;
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid       <= 1'b1;
		req_ch.opcode      <= op;
		req_ch.value       <= val;
		req_ch.random_word <= rnd;
		do @(posedge clk); while (!req_ch.ready);
		exp_item = apply_set_op(op, val, rnd);
		expected_results = {expected_results, exp_item};
		words_sent++;
		ops_sent[op]++;
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] choose_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
		if (r < 80 && shadow_count > 0) return shadow_members[$urandom_range(0, shadow_count - 1)];
		return $urandom();
	endfunction

	task automatic test_directed_cases();
		sender_idle_en   = 1'b1;
		receiver_idle_en = 1'b1;
		send_word(OP_PICK, 32'h0, 16'h0);
		send_word(OP_REMOVE, 32'h0, 16'h0);
		send_word(OP_UNUSED, 32'hffffffff, 16'hffff);
		send_word(OP_INSERT, 32'h80000000, 16'h0);
		send_word(OP_INSERT, 32'h7fffffff, 16'hffff);
		send_word(OP_INSERT, 32'h00000000, 16'h0);
		send_word(OP_INSERT, 32'hffffffff, 16'h0);
		send_word(OP_INSERT, 32'h7fffffff, 16'h0);
		send_word(OP_PICK, 32'h0, 16'h0000);
		send_word(OP_PICK, 32'h0, 16'hffff);
		send_word(OP_PICK, 32'h0, 16'h0003);
		send_word(OP_UNUSED, 32'h7fffffff, 16'hffff);
		send_word(OP_REMOVE, 32'h12345678, 16'h0);
		send_word(OP_REMOVE, 32'h80000000, 16'h0);
		send_word(OP_REMOVE, 32'hffffffff, 16'h0);
		send_word(OP_PICK, 32'h0, 16'h0001);
		send_word(OP_REMOVE, 32'h00000000, 16'h0);
		send_word(OP_REMOVE, 32'h7fffffff, 16'h0);
		send_word(OP_PICK, 32'hffffffff, 16'hffff);
		send_word(OP_INSERT, 32'h55555555, 16'h5555);
		send_word(OP_INSERT, 32'haaaaaaaa, 16'haaaa);
		send_word(OP_REMOVE, 32'h55555555, 16'h0);
		send_word(OP_REMOVE, 32'haaaaaaaa, 16'h0);
		wait_results_drained();
	endtask

	// grow the set to capacity, poke the full store, then remove every member and one absent value
	task automatic test_fill_and_empty(input bit with_idle);
		logic [VALUE_W-1:0] member;
		sender_idle_en   = with_idle;
		receiver_idle_en = with_idle;
		while (shadow_count < CAPACITY) send_word(OP_INSERT, $urandom(), $urandom_range(0, 65535));
		send_word(OP_INSERT, $urandom(), 16'h0);
		send_word(OP_INSERT, shadow_members[$urandom_range(0, CAPACITY - 1)], 16'h0);
		send_word(OP_INSERT, shadow_members[CAPACITY - 1], 16'h0);
		send_word(OP_PICK, 32'h0, 16'hffff);
		send_word(OP_PICK, 32'h0, 16'h0000);
		send_word(OP_PICK, 32'h0, 16'(CAPACITY - 1));
		send_word(OP_PICK, 32'h0, 16'(CAPACITY));
		send_word(OP_UNUSED, $urandom(), $urandom_range(0, 65535));
		while (shadow_count > 0) begin
			member = shadow_members[$urandom_range(0, shadow_count - 1)];
			send_word(OP_REMOVE, member, $urandom_range(0, 65535));
			if ($urandom_range(0, 3) == 0) send_word(OP_PICK, $urandom(), $urandom_range(0, 65535));
		end
		send_word(OP_REMOVE, member, 16'h0);
		wait_results_drained();
	endtask

	// receiver holds off while the sender keeps offering words
	task automatic test_stall_backpressure();
		sender_idle_en   = 1'b0;
		receiver_idle_en = 1'b0;
		hold_len = 300;
		for (int i = 0; i < 8; i++) begin
			send_word((i % 3 == 2) ? OP_PICK : OP_INSERT, value_pool[i], $urandom_range(0, 65535));
		end
		wait_results_drained();
	endtask

	task automatic test_random_mix();
		int ins_w;
		int rm_w;
		int r;
		logic [OPC_W-1:0] op;
		ins_w = 45;
		rm_w  = 28;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// change the insert/remove bias every hundred words so full and empty both recur
			if (n % 100 == 0) begin
				case ($urandom_range(0, 2))
					0: ins_w = 20;
					1: ins_w = 45;
					default: ins_w = 70;
				endcase
				rm_w = (92 - ins_w) * 6 / 10;
				sender_idle_en   = ($urandom_range(0, 3) != 0);
				receiver_idle_en = ($urandom_range(0, 3) != 0);
			end
			r = $urandom_range(0, 99);
			if (r < ins_w) op = OP_INSERT;
			else if (r < ins_w + rm_w) op = OP_REMOVE;
			else if (r < 96) op = OP_PICK;
			else op = OP_UNUSED;
			send_word(op, choose_value(), $urandom_range(0, 65535));
		end
		wait_results_drained();
	endtask

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.opcode      = OP_INSERT;
		req_ch.value       = '0;
		req_ch.random_word = '0;
		fail_count         = 0;
		cycle_count        = 0;
		words_sent         = 0;
		results_checked    = 0;
		hold_len           = 0;
		shadow_count       = 0;
		sender_idle_en     = 1'b0;
		receiver_idle_en   = 1'b0;
		for (int i = 0; i < 4; i++) begin
			ops_sent[i]    = 0;
			status_seen[i] = 0;
		end
		for (int i = 0; i < POOL_SIZE; i++) value_pool[i] = $urandom();
		value_pool[0] = 32'h80000000;
		value_pool[1] = 32'h7fffffff;
		value_pool[2] = 32'h00000000;
		value_pool[3] = 32'hffffffff;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_fill_and_empty(1'b0);
		test_stall_backpressure();
		test_fill_and_empty(1'b1);
		test_random_mix();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d words: %0d insert, %0d remove, %0d pick, %0d unused opcode",
			words_sent, ops_sent[OP_INSERT], ops_sent[OP_REMOVE], ops_sent[OP_PICK],
			ops_sent[OP_UNUSED]);
		$display("checked %0d results: %0d done, %0d no change, %0d full, %0d empty, %0d failures",
			results_checked, status_seen[ST_DONE], status_seen[ST_NOCHG], status_seen[ST_FULL],
			status_seen[ST_EMPTY], fail_count);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("** randomized_set_table_unit: PASSED **");
		end else begin
			$display("** randomized_set_table_unit: FAILED **");
		end
		$finish;
	end
endmodule
